@@ hw/rtl/hte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

	// bits per output beat, and zero bits appended by a flush
	localparam int BYTE_BITS  = 8;
	localparam int FLUSH_BITS = 7;

	// bit accumulator: up to seven unsent bits and their count
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_LOAD   = 2'd0;
	localparam kind_t KIND_ENCODE = 2'd1;
	localparam kind_t KIND_FLUSH  = 2'd2;

	// control of the item held after the table read
	typedef struct packed {
		logic  vld;
		kind_t kind;
		logic  hit;
	} s1_ctl_t;

	// bytes completed by one item, byte0 goes out first
	typedef struct packed {
		logic [1:0]           cnt;
		logic [BYTE_BITS-1:0] byte0;
		logic [BYTE_BITS-1:0] byte1;
	} emit_t;

endpackage

`default_nettype wire

@@ hw/rtl/huffman_table_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted encode or flush beat has its table entry read while it is registered in
//   stage 1; its bytes are then packed into the output buffer registers once they fit there.
// Throughput: one input beat per cycle while in_stall is low; an item that completes two
//   bytes fills both buffer entries behind the single output port, so long codes can stall the input.
// Reset (arst_n low, asynchronous): clears control, the bit accumulator and the per-symbol
//   valid bits; the code RAM itself is not cleared and needs no clearing pass.
module huffman_table_encoder #(
	parameter int MAX_CODE_BITS = 16,
	parameter int SYMBOL_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  symbol,
	input  logic [15:0] code_word,
	input  logic [4:0]  code_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	// stored code bits: longer lengths are clamped on load
	localparam int LEN_CAP = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;
	localparam int LEN_W   = $clog2(LEN_CAP + 1);
	localparam int SYM_W   = $clog2(SYMBOL_COUNT);
	localparam int ENT_W   = LEN_CAP + LEN_W;

	// ---------------- input side ----------------
	logic               in_acc;
	logic               in_range;
	logic [SYM_W-1:0]   sym_idx;
	logic               ld;
	logic [LEN_W-1:0]   len_clamp;
	logic [ENT_W-1:0]   wr_data;
	logic [ENT_W-1:0]   rd_data;

	// one valid bit per symbol stands in for the zero reset of the length table
	logic [SYMBOL_COUNT-1:0] vld_q;

	hte_pkg::s1_ctl_t   ctl_s1;
	hte_pkg::emit_t     emit;
	logic               adv;
	logic               fits;

	// ---------------- output buffer ----------------
	// two-entry queue; entry 0 drives the ports
	logic [1:0]         cnt_q;
	logic [7:0]         b0_q;
	logic [7:0]         b1_q;
	logic               l0_q;
	logic               l1_q;
	logic               take;
	logic [1:0]         keep;
	logic [1:0]         push;
	logic [2:0]         room_need;
	logic [7:0]         nb0;
	logic [7:0]         nb1;
	logic               nl0;
	logic               nl1;

	assign in_acc    = in_valid && !in_stall;
	assign in_range  = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign sym_idx   = symbol[SYM_W-1:0];
	assign ld        = in_acc && (kind == hte_pkg::KIND_LOAD) && in_range;
	assign len_clamp = (code_length > 5'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length[LEN_W-1:0];
	assign wr_data   = {code_word[LEN_CAP-1:0], len_clamp};

	// code word and length in one entry; read enabled only on accept so the
	// data holds while the packing stage waits
	hte_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (ld),
		.wr_addr (sym_idx),
		.wr_data (wr_data),
		.rd_en   (in_acc),
		.rd_addr (sym_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ld) begin
			vld_q[sym_idx] <= 1'b1;
		end
	end

	// stage 1: item waits here while its table entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (!in_stall) begin
			ctl_s1.vld  <= in_acc;
			ctl_s1.kind <= kind;
			ctl_s1.hit  <= in_range && vld_q[sym_idx];
		end
	end

	hte_pack #(
		.LEN_CAP (LEN_CAP),
		.LEN_W   (LEN_W)
	) u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.code   (rd_data[ENT_W-1:LEN_W]),
		.len    (rd_data[LEN_W-1:0]),
		.adv    (adv),
		.emit   (emit)
	);

	// stage 1 moves on when its bytes fit behind what the buffer keeps this cycle
	assign take      = out_valid && !out_stall;
	assign keep      = cnt_q - {1'b0, take};
	assign room_need = {1'b0, keep} + {1'b0, emit.cnt};
	assign fits      = room_need <= 3'd2;
	assign adv       = ctl_s1.vld && fits;
	assign in_stall  = ctl_s1.vld && !fits;
	assign push      = adv ? emit.cnt : 2'd0;

	always_comb begin
		nb0 = take ? b1_q : b0_q;
		nl0 = take ? l1_q : l0_q;
		nb1 = b1_q;
		nl1 = l1_q;
		case (keep)
			2'd0: begin
				if (push != 2'd0) begin
					nb0 = emit.byte0;
					nl0 = (push == 2'd1);
				end
				if (push == 2'd2) begin
					nb1 = emit.byte1;
					nl1 = 1'b1;
				end
			end
			2'd1: begin
				if (push != 2'd0) begin
					nb1 = emit.byte0;
					nl1 = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= keep + push;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		b0_q <= nb0;
		b1_q <= nb1;
		l0_q <= nl0;
		l1_q <= nl1;
	end

	assign out_valid   = cnt_q != 2'd0;
	assign out_byte    = b0_q;
	assign last_of_run = l0_q;

`ifndef SYNTHESIS
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overfilled");
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ctl_s1.vld)
		else $error("input stalled with an empty stage 1");
	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output beat dropped");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/hte_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hte_pack.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hte_pack #(
	parameter int LEN_CAP = 16,
	parameter int LEN_W   = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hte_pkg::s1_ctl_t   ctl,
	input  logic [LEN_CAP-1:0] code,
	input  logic [LEN_W-1:0]   len,
	input  logic               adv,
	output hte_pkg::emit_t     emit
);

	localparam int ACC_W = hte_pkg::PEND_W + LEN_CAP;
	localparam int TOT_W = $clog2(ACC_W + 1);

	logic [hte_pkg::PEND_W-1:0] pbits_q;
	logic [hte_pkg::PCNT_W-1:0] pcnt_q;

	logic [TOT_W-1:0]           a_len;
	logic [ACC_W-1:0]           a_bits;
	logic [ACC_W-1:0]           acc;
	logic [TOT_W:0]             total;
	logic [TOT_W:0]             sh0;
	logic [TOT_W:0]             sh1;
	logic                       n1;
	logic                       n2;
	logic [hte_pkg::PCNT_W-1:0] rem;
	logic [hte_pkg::PEND_W-1:0] pbits_d;

	always_comb begin
		if (ctl.kind == hte_pkg::KIND_FLUSH) begin
			a_len  = TOT_W'(hte_pkg::FLUSH_BITS);
			a_bits = '0;
		end else if (ctl.kind == hte_pkg::KIND_ENCODE && ctl.hit) begin
			a_len  = TOT_W'(len);
			a_bits = ACC_W'(code) & ~({ACC_W{1'b1}} << a_len);
		end else begin
			a_len  = '0;
			a_bits = '0;
		end

		acc   = (ACC_W'(pbits_q) << a_len) | a_bits;
		total = (TOT_W + 1)'(pcnt_q) + (TOT_W + 1)'(a_len);
		sh0   = total - (TOT_W + 1)'(hte_pkg::BYTE_BITS);
		sh1   = total - (TOT_W + 1)'(2 * hte_pkg::BYTE_BITS);
		n2    = total >= (TOT_W + 1)'(2 * hte_pkg::BYTE_BITS);
		n1    = !n2 && (total >= (TOT_W + 1)'(hte_pkg::BYTE_BITS));

		if (n2) begin
			rem = hte_pkg::PCNT_W'(sh1);
		end else if (n1) begin
			rem = hte_pkg::PCNT_W'(sh0);
		end else begin
			rem = hte_pkg::PCNT_W'(total);
		end
		pbits_d = hte_pkg::PEND_W'(acc) & ~({hte_pkg::PEND_W{1'b1}} << rem);

		emit.cnt   = n2 ? 2'd2 : (n1 ? 2'd1 : 2'd0);
		emit.byte0 = hte_pkg::BYTE_BITS'(acc >> sh0);
		emit.byte1 = hte_pkg::BYTE_BITS'(acc >> sh1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (adv) begin
			pbits_q <= pbits_d;
			pcnt_q  <= rem;
		end
	end

`ifndef SYNTHESIS
	a_load_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl.kind == hte_pkg::KIND_LOAD) |=> ($stable(pcnt_q) && $stable(pbits_q)))
		else $error("load beat changed the bit accumulator");
	a_empty_flush_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld && ctl.kind == hte_pkg::KIND_FLUSH && pcnt_q == '0) |-> (emit.cnt == 2'd0))
		else $error("flush with nothing pending produced a byte");
`endif

endmodule

`default_nettype wire
